// ----- rtl/sswb_pkg.sv -----
package sswb_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAP_BITS  = 16;
  localparam int SEQ_W     = 32;
  localparam int KEY_W     = 64;
  localparam int RATE_W    = 16;
  localparam int CNT_OUT_W = 5;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WRONG_KEY = 3'd1;
  localparam logic [2:0] ST_TOO_OLD   = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SPAN,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  stamp;
    logic [SEQ_W-1:0]  size;
    logic [RATE_W-1:0] rate;
  } slot_t;

endpackage

// ----- rtl/sswb_req_if.sv -----
interface sswb_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [sswb_pkg::KEY_W-1:0]          key_high;
  logic [sswb_pkg::KEY_W-1:0]          key_low;
  logic [sswb_pkg::SEQ_W-1:0]          seq_number;
  logic [sswb_pkg::SEQ_W-1:0]          time_stamp;
  logic [sswb_pkg::SEQ_W-1:0]          byte_size;
  logic [sswb_pkg::RATE_W-1:0]         kbit_rate;

  modport source (
    output valid, action, key_high, key_low, seq_number, time_stamp, byte_size, kbit_rate,
    input  ready
  );
  modport sink (
    input  valid, action, key_high, key_low, seq_number, time_stamp, byte_size, kbit_rate,
    output ready
  );
endinterface

// ----- rtl/sswb_rsp_if.sv -----
interface sswb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          status;
  logic [sswb_pkg::SEQ_W-1:0]          found_time_stamp;
  logic [sswb_pkg::SEQ_W-1:0]          found_byte_size;
  logic [sswb_pkg::RATE_W-1:0]         found_kbit_rate;
  logic [sswb_pkg::SEQ_W-1:0]          oldest_seq;
  logic [sswb_pkg::SEQ_W-1:0]          newest_seq;
  logic [sswb_pkg::CNT_OUT_W-1:0]      entry_count;
  logic [sswb_pkg::MAP_BITS-1:0]       presence_map;

  modport source (
    output valid, status, found_time_stamp, found_byte_size, found_kbit_rate,
           oldest_seq, newest_seq, entry_count, presence_map,
    input  ready
  );
  modport sink (
    input  valid, status, found_time_stamp, found_byte_size, found_kbit_rate,
           oldest_seq, newest_seq, entry_count, presence_map,
    output ready
  );
endinterface

// ----- rtl/segment_sequence_window_buffer_unit.sv -----
// Sliding window of SLOTS segment descriptors for one stream, with duplicate check. Each request
// beat (add, lookup or clear) yields exactly one response beat that reports the status, the found
// descriptor on a lookup, and the window (oldest, newest, count, 16-bit presence map relative to
// oldest). One request is worked on at a time, through the states prep, span, walk over all
// slots, drain and finish; finish holds while the previous response is still unaccepted, and
// a new request beat is accepted only after finish. The descriptors sit in one memory
// with a single registered read port, and one pass over all slots through that port serves the
// duplicate search, the lookup and the presence map together. A finished response waits in an
// output register, and the next request is taken meanwhile.
module segment_sequence_window_buffer_unit #(
  parameter int SLOTS = sswb_pkg::SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sswb_req_if.sink   req,
  sswb_rsp_if.source rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = sswb_pkg::SEQ_W;
  localparam int MB = sswb_pkg::MAP_BITS;
  localparam int MW = $clog2(MB);
  localparam logic [SW-1:0] SLOTS_SEQ = SW'(SLOTS);
  localparam logic [SW-1:0] SLOTS_M1  = SW'(SLOTS - 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);

  sswb_pkg::state_t state, state_next;

  sswb_pkg::slot_t mem [SLOTS];
  sswb_pkg::slot_t rd_data;

  logic [SLOTS-1:0]             valid_bits;
  logic [IW-1:0]                wp;
  logic [SW-1:0]                oldest;
  logic [SW-1:0]                newest;
  logic [CW-1:0]                count;
  logic [sswb_pkg::KEY_W-1:0]   key_hi;
  logic [sswb_pkg::KEY_W-1:0]   key_lo;

  logic [1:0]                   a_act;
  logic [sswb_pkg::KEY_W-1:0]   a_key_hi;
  logic [sswb_pkg::KEY_W-1:0]   a_key_lo;
  logic [SW-1:0]                a_seq;
  logic [SW-1:0]                a_time;
  logic [SW-1:0]                a_size;
  logic [sswb_pkg::RATE_W-1:0]  a_rate;

  logic                         key_bad;
  logic                         too_old;
  logic [SW-1:0]                newest_a;
  logic [SW-1:0]                oldest_a;
  logic [CW-1:0]                count_a;
  logic [SW-1:0]                span_k;
  logic [SW-1:0]                span_a;
  logic                         win_k;
  logic                         win_a;

  logic [IW-1:0]                rd_idx;
  logic [IW-1:0]                rd_idx_q;
  logic                         rd_pend;
  logic                         rd_ok;

  logic                         found;
  logic [SW-1:0]                f_time;
  logic [SW-1:0]                f_size;
  logic [sswb_pkg::RATE_W-1:0]  f_rate;
  logic [MB-1:0]                map_k;
  logic [MB-1:0]                map_a;

  logic                         o_valid;
  logic [2:0]                   o_status;
  logic [SW-1:0]                o_time;
  logic [SW-1:0]                o_size;
  logic [sswb_pkg::RATE_W-1:0]  o_rate;
  logic [SW-1:0]                o_oldest;
  logic [SW-1:0]                o_newest;
  logic [sswb_pkg::CNT_OUT_W-1:0] o_count;
  logic [MB-1:0]                o_map;

  logic          take;
  logic          walk_rd;
  logic          fin_go;
  logic [SW-1:0] newest_c;
  logic [SW-1:0] d_k;
  logic [SW-1:0] d_a;
  logic [SW-1:0] d_n;
  logic          hit;
  logic          commit;
  logic [2:0]    status_c;
  logic [MB-1:0] map_c;
  logic [IW-1:0] wp_inc;

  // control decode
  always_comb begin
    take    = 1'b0;
    walk_rd = 1'b0;
    fin_go  = 1'b0;
    case (state)
      sswb_pkg::S_IDLE:   take    = req.valid;
      sswb_pkg::S_WALK:   walk_rd = 1'b1;
      sswb_pkg::S_FINISH: fin_go  = !o_valid || rsp.ready;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sswb_pkg::S_IDLE:   if (take) state_next = sswb_pkg::S_PREP;
      sswb_pkg::S_PREP:   state_next = sswb_pkg::S_SPAN;
      sswb_pkg::S_SPAN:   state_next = sswb_pkg::S_WALK;
      sswb_pkg::S_WALK:   if (rd_idx == LAST_IDX) state_next = sswb_pkg::S_DRAIN;
      sswb_pkg::S_DRAIN:  state_next = sswb_pkg::S_FINISH;
      sswb_pkg::S_FINISH: if (fin_go) state_next = sswb_pkg::S_IDLE;
      default:            state_next = sswb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sswb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req.ready = (state == sswb_pkg::S_IDLE);

  // window candidates for an accepted add
  assign newest_c = (a_seq > newest || count == '0) ? a_seq : newest;

  always_ff @(posedge clk) begin
    if (take) begin
      a_act    <= req.action;
      a_key_hi <= req.key_high;
      a_key_lo <= req.key_low;
      a_seq    <= req.seq_number;
      a_time   <= req.time_stamp;
      a_size   <= req.byte_size;
      a_rate   <= req.kbit_rate;
    end
    if (state == sswb_pkg::S_PREP) begin
      key_bad  <= (count != '0) && ({key_hi, key_lo} != {a_key_hi, a_key_lo});
      too_old  <= (count != '0) && (newest >= SLOTS_SEQ) && (a_seq <= newest - SLOTS_SEQ);
      newest_a <= newest_c;
      if (count < SLOTS_CNT) begin
        oldest_a <= (count == '0) ? a_seq : oldest;
        count_a  <= count + 1'b1;
      end else begin
        oldest_a <= newest_c - SLOTS_M1;
        count_a  <= count;
      end
      span_k <= newest - oldest;
      win_k  <= (count != '0) && (newest >= oldest);
    end
    if (state == sswb_pkg::S_SPAN) begin
      span_a <= newest_a - oldest_a;
      win_a  <= newest_a >= oldest_a;
    end
  end

  // slot walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= walk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_idx <= '0;
    end else if (walk_rd) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (walk_rd) begin
      rd_idx_q <= rd_idx;
      rd_ok    <= valid_bits[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (walk_rd) begin
      rd_data <= mem[rd_idx];
    end
    if (fin_go && commit) begin
      mem[wp] <= '{seq: a_seq, stamp: a_time, size: a_size, rate: a_rate};
    end
  end

  assign hit = rd_ok && (rd_data.seq == a_seq);
  assign d_k = rd_data.seq - oldest;
  assign d_a = rd_data.seq - oldest_a;

  always_ff @(posedge clk) begin
    if (take) begin
      found <= 1'b0;
      map_k <= '0;
      map_a <= '0;
    end else if (rd_pend) begin
      if (hit && !found) begin
        found  <= 1'b1;
        f_time <= rd_data.stamp;
        f_size <= rd_data.size;
        f_rate <= rd_data.rate;
      end
      if (rd_ok && d_k <= span_k && d_k < SW'(MB)) begin
        map_k[d_k[MW-1:0]] <= 1'b1;
      end
      if (rd_ok && rd_idx_q != wp && d_a <= span_a && d_a < SW'(MB)) begin
        map_a[d_a[MW-1:0]] <= 1'b1;
      end
    end
  end

  // result and commit
  assign d_n    = a_seq - oldest_a;
  assign wp_inc = (wp == LAST_IDX) ? '0 : wp + 1'b1;

  always_comb begin
    commit   = 1'b0;
    status_c = sswb_pkg::ST_OK;
    map_c    = win_k ? map_k : '0;
    case (a_act)
      sswb_pkg::ACT_ADD: begin
        if (key_bad) begin
          status_c = sswb_pkg::ST_WRONG_KEY;
        end else if (too_old) begin
          status_c = sswb_pkg::ST_TOO_OLD;
        end else if (found) begin
          status_c = sswb_pkg::ST_DUPLICATE;
        end else begin
          commit = 1'b1;
          map_c  = '0;
          if (win_a) begin
            map_c = map_a;
            if (d_n <= span_a && d_n < SW'(MB)) begin
              map_c[d_n[MW-1:0]] = 1'b1;
            end
          end
        end
      end
      sswb_pkg::ACT_LOOKUP: begin
        if (!found) status_c = sswb_pkg::ST_NOT_FOUND;
      end
      sswb_pkg::ACT_CLEAR: begin
        map_c = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      wp         <= '0;
      oldest     <= '0;
      newest     <= '0;
      count      <= '0;
      key_hi     <= '0;
      key_lo     <= '0;
    end else if (fin_go) begin
      if (a_act == sswb_pkg::ACT_CLEAR) begin
        valid_bits <= '0;
        wp         <= '0;
        oldest     <= '0;
        newest     <= '0;
        count      <= '0;
        key_hi     <= '0;
        key_lo     <= '0;
      end else if (commit) begin
        valid_bits[wp] <= 1'b1;
        wp             <= wp_inc;
        oldest         <= oldest_a;
        newest         <= newest_a;
        count          <= count_a;
        if (count == '0) begin
          key_hi <= a_key_hi;
          key_lo <= a_key_lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fin_go) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      o_status <= status_c;
      o_map    <= map_c;
      if (a_act == sswb_pkg::ACT_LOOKUP && found) begin
        o_time <= f_time;
        o_size <= f_size;
        o_rate <= f_rate;
      end else begin
        o_time <= '0;
        o_size <= '0;
        o_rate <= '0;
      end
      if (a_act == sswb_pkg::ACT_CLEAR) begin
        o_oldest <= '0;
        o_newest <= '0;
        o_count  <= '0;
      end else if (commit) begin
        o_oldest <= oldest_a;
        o_newest <= newest_a;
        o_count  <= sswb_pkg::CNT_OUT_W'(count_a);
      end else begin
        o_oldest <= oldest;
        o_newest <= newest;
        o_count  <= sswb_pkg::CNT_OUT_W'(count);
      end
    end
  end

  assign rsp.valid            = o_valid;
  assign rsp.status           = o_status;
  assign rsp.found_time_stamp = o_time;
  assign rsp.found_byte_size  = o_size;
  assign rsp.found_kbit_rate  = o_rate;
  assign rsp.oldest_seq       = o_oldest;
  assign rsp.newest_seq       = o_newest;
  assign rsp.entry_count      = o_count;
  assign rsp.presence_map     = o_map;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SLOTS_CNT)
    else $error("slot count above ring size");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_bits) == int'(count))
    else $error("valid slots disagree with count");

  a_wp_fill: assert property (@(posedge clk) disable iff (rst)
    (count < SLOTS_CNT) |-> (wp == IW'(count)))
    else $error("write pointer out of step with fill level");

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == sswb_pkg::S_PREP))
    else $error("accepted beat did not start work");

  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    (state == sswb_pkg::S_DRAIN) |-> (rd_pend && rd_idx_q == LAST_IDX))
    else $error("slot walk ended early");

endmodule
